/* design/iabd_pkg.sv */
// ----------------------------------------------------------------------------
// IMA ADPCM block decoder package
// Shared command format, op codes, register indexes and the IMA tables.
// ----------------------------------------------------------------------------
package iabd_pkg;

  localparam int CMDQ_DEPTH = 4;
  localparam int OUTQ_DEPTH = 4;

  // Configuration register indexes.
  localparam logic REG_BLOCK_ALIGN  = 1'b0;
  localparam logic REG_SAMPLE_COUNT = 1'b1;

  localparam logic [12:0] ALIGN_RESET = 13'd256;
  localparam logic [31:0] COUNT_RESET = 32'd4;
  localparam int          MIN_ALIGN   = 5;
  localparam logic [31:0] MIN_COUNT   = 32'd4;

  // Header byte positions within a block.
  localparam int HDR_PRED_LO = 0;
  localparam int HDR_PRED_HI = 1;
  localparam int HDR_INDEX   = 2;
  localparam int HDR_RSVD    = 3;
  localparam int HDR_LEN     = 4;

  localparam logic [6:0]         IDX_MAX  = 7'd88;
  localparam logic [3:0]         NIB_MASK = 4'hF;
  localparam logic signed [17:0] PCM_MIN  = -18'sd32768;
  localparam logic signed [17:0] PCM_MAX  = 18'sd32767;

  // Command op codes passed from the front end to the back end.
  localparam logic [2:0] OP_LOAD_PRED = 3'd0;
  localparam logic [2:0] OP_LOAD_IDX  = 3'd1;
  localparam logic [2:0] OP_EMIT      = 3'd2;
  localparam logic [2:0] OP_NIB       = 3'd3;
  localparam logic [2:0] OP_CLR       = 3'd4;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] data;
    logic        run_end;
    logic        count_reached;
    logic        clr;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               run_end;
    logic               count_reached;
  } samp_t;

  function automatic logic signed [4:0] idx_adjust(input logic [2:0] code);
    logic signed [4:0] adj;
    case (code)
      3'd4:    adj = 5'sd2;
      3'd5:    adj = 5'sd4;
      3'd6:    adj = 5'sd6;
      3'd7:    adj = 5'sd8;
      default: adj = -5'sd1;
    endcase
    return adj;
  endfunction

  function automatic logic [14:0] step_size(input logic [6:0] ix);
    logic [14:0] s;
    case (ix)
      7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
      7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
      7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
      7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
      7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
      7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
      7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
      7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
      7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
      7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
      7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
      7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
      7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
      7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
      7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
      7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
      7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
      7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
      7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
      7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
      7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
      7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
      7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
      7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
      7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
      7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
      7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
      7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
      7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
      7'd87: s = 15'd29794;
      default: s = 15'd32767;
    endcase
    return s;
  endfunction

endpackage

/* design/iabd_fifo.sv */
// ----------------------------------------------------------------------------
// IMA ADPCM decoder queue
// Small first-in first-out buffer with count-based full and empty flags.
// ----------------------------------------------------------------------------
module iabd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

/* design/iabd_front.sv */
// ----------------------------------------------------------------------------
// IMA ADPCM decoder front end
// Tracks block position and sample count, and turns each byte into commands.
// ----------------------------------------------------------------------------
module iabd_front #(
  parameter int MAX_BLOCK_ALIGN = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 in_push,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_last_byte,
  output logic                 in_full,
  output logic                 cmd_push,
  output iabd_pkg::cmd_t       cmd_data,
  input  logic                 cmd_full
);

  localparam int BW = $clog2(MAX_BLOCK_ALIGN);
  localparam int AW = (BW + 1 > 13) ? BW + 1 : 13;

  logic [12:0]     align_r;
  logic [31:0]     count_r;
  logic [BW-1:0]   bib_r, bib_nxt;
  logic [7:0]      hdr_low_r, hdr_low_nxt;
  logic [31:0]     done_r, done_nxt;
  logic            pend_r, pend_nxt;
  iabd_pkg::cmd_t  pend_op_r, pend_op_nxt;

  logic            accept;
  logic [AW-1:0]   align;
  logic [AW-1:0]   bib_plus;
  logic            enabled;
  logic [32:0]     done_ext;
  logic [32:0]     count_ext;
  logic            e1, e2, cr1, cr2;
  logic            op_valid;
  iabd_pkg::cmd_t  op;

  assign accept  = in_push && !in_full;
  assign in_full = pend_r || cmd_full;

  always_comb begin
    align = (AW'(align_r) > AW'(MAX_BLOCK_ALIGN)) ? AW'(MAX_BLOCK_ALIGN) : AW'(align_r);
    enabled   = (align >= AW'(iabd_pkg::MIN_ALIGN)) && (count_r >= iabd_pkg::MIN_COUNT);
    bib_plus  = AW'(bib_r) + 1'b1;
    done_ext  = {1'b0, done_r};
    count_ext = {1'b0, count_r};
    e1  = done_r < count_r;
    e2  = e1 && ((done_ext + 33'd1) < count_ext);
    cr1 = (done_ext + 33'd1) == count_ext;
    cr2 = (done_ext + 33'd2) == count_ext;
  end

  always_comb begin
    bib_nxt     = bib_r;
    hdr_low_nxt = hdr_low_r;
    done_nxt    = done_r;
    pend_nxt    = pend_r;
    pend_op_nxt = pend_op_r;
    op_valid    = 1'b0;
    op          = '0;

    if (pend_r && !cmd_full) begin
      pend_nxt = 1'b0;
    end

    if (accept) begin
      if (enabled) begin
        unique case (bib_r)
          BW'(iabd_pkg::HDR_PRED_LO): begin
            hdr_low_nxt = in_data_byte;
            bib_nxt     = BW'(iabd_pkg::HDR_PRED_HI);
          end
          BW'(iabd_pkg::HDR_PRED_HI): begin
            op_valid = 1'b1;
            op.op    = iabd_pkg::OP_LOAD_PRED;
            op.data  = {in_data_byte, hdr_low_r};
            bib_nxt  = BW'(iabd_pkg::HDR_INDEX);
          end
          BW'(iabd_pkg::HDR_INDEX): begin
            op_valid = 1'b1;
            op.op    = iabd_pkg::OP_LOAD_IDX;
            op.data  = (in_data_byte > {1'b0, iabd_pkg::IDX_MAX}) ?
                       16'(iabd_pkg::IDX_MAX) : 16'(in_data_byte);
            bib_nxt  = BW'(iabd_pkg::HDR_RSVD);
          end
          BW'(iabd_pkg::HDR_RSVD): begin
            if (!in_last_byte && e1) begin
              op_valid         = 1'b1;
              op.op            = iabd_pkg::OP_EMIT;
              op.run_end       = 1'b1;
              op.count_reached = cr1;
              done_nxt         = done_r + 32'd1;
            end
            bib_nxt = BW'(iabd_pkg::HDR_LEN);
          end
          default: begin
            if (e1) begin
              op_valid         = 1'b1;
              op.op            = iabd_pkg::OP_NIB;
              op.data          = {12'd0, in_data_byte[3:0] & iabd_pkg::NIB_MASK};
              op.run_end       = !e2;
              op.count_reached = cr1;
              done_nxt         = done_r + 32'd1;
            end
            if (e2) begin
              pend_nxt                 = 1'b1;
              pend_op_nxt              = '0;
              pend_op_nxt.op           = iabd_pkg::OP_NIB;
              pend_op_nxt.data         = {12'd0, in_data_byte[7:4] & iabd_pkg::NIB_MASK};
              pend_op_nxt.run_end      = 1'b1;
              pend_op_nxt.count_reached = cr2;
              done_nxt                 = done_r + 32'd2;
            end
            bib_nxt = (bib_plus >= align) ? '0 : BW'(bib_plus);
          end
        endcase
      end

      // A last byte clears the whole stream state on both sides.
      if (in_last_byte) begin
        bib_nxt     = '0;
        hdr_low_nxt = '0;
        done_nxt    = '0;
        if (pend_nxt) begin
          pend_op_nxt.clr = 1'b1;
        end else if (op_valid &&
                     (op.op == iabd_pkg::OP_EMIT || op.op == iabd_pkg::OP_NIB)) begin
          op.clr = 1'b1;
        end else begin
          op_valid = 1'b1;
          op       = '0;
          op.op    = iabd_pkg::OP_CLR;
          op.clr   = 1'b1;
        end
      end
    end
  end

  assign cmd_push = pend_r ? !cmd_full : op_valid;
  assign cmd_data = pend_r ? pend_op_r : op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      align_r   <= iabd_pkg::ALIGN_RESET;
      count_r   <= iabd_pkg::COUNT_RESET;
      bib_r     <= '0;
      hdr_low_r <= '0;
      done_r    <= '0;
      pend_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == iabd_pkg::REG_BLOCK_ALIGN) begin
          align_r <= cfg_data[12:0];
        end else begin
          count_r <= cfg_data;
        end
      end
      bib_r     <= bib_nxt;
      hdr_low_r <= hdr_low_nxt;
      done_r    <= done_nxt;
      pend_r    <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_op_r <= pend_op_nxt;
  end

  // A held second nibble must keep the input side closed.
  assert property (@(posedge clk) disable iff (!rst_n) pend_r |-> in_full)
    else $error("input open while a second nibble is pending");

  // A command is never offered to a full queue.
  assert property (@(posedge clk) disable iff (!rst_n) !(cmd_push && cmd_full))
    else $error("command pushed into a full queue");

  // A last byte leaves the stream position and sample count at zero.
  assert property (@(posedge clk) disable iff (!rst_n)
      (accept && in_last_byte) |=> (bib_r == '0 && done_r == '0))
    else $error("stream state not cleared after last byte");

endmodule

/* design/iabd_back.sv */
// ----------------------------------------------------------------------------
// IMA ADPCM decoder back end
// Holds predictor and step index; runs one command per cycle unless out_full.
// ----------------------------------------------------------------------------
module iabd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  iabd_pkg::cmd_t  cmd_data,
  input  logic            cmd_empty,
  output logic            cmd_pop,
  output logic            out_push,
  output iabd_pkg::samp_t out_data,
  input  logic            out_full
);

  logic signed [15:0] pred_r, pred_nxt;
  logic [6:0]         idx_r, idx_nxt;
  logic               fire;

  logic [3:0]         nib;
  logic [14:0]        step;
  logic [16:0]        diff;
  logic signed [17:0] psum;
  logic signed [15:0] dec_pred;
  logic signed [4:0]  adj;
  logic signed [7:0]  ni;
  logic [6:0]         dec_idx;

  assign fire    = !cmd_empty && !out_full;
  assign cmd_pop = fire;

  always_comb begin
    nib  = cmd_data.data[3:0];
    step = iabd_pkg::step_size(idx_r);
    diff = 17'(step >> 3);
    if (nib[0]) diff = diff + 17'(step >> 2);
    if (nib[1]) diff = diff + 17'(step >> 1);
    if (nib[2]) diff = diff + 17'(step);
    if (nib[3]) begin
      psum = 18'(pred_r) - $signed({1'b0, diff});
    end else begin
      psum = 18'(pred_r) + $signed({1'b0, diff});
    end
    if (psum < iabd_pkg::PCM_MIN) begin
      dec_pred = 16'(iabd_pkg::PCM_MIN);
    end else if (psum > iabd_pkg::PCM_MAX) begin
      dec_pred = 16'(iabd_pkg::PCM_MAX);
    end else begin
      dec_pred = psum[15:0];
    end
    adj = iabd_pkg::idx_adjust(nib[2:0]);
    ni  = $signed({1'b0, idx_r}) + $signed({{3{adj[4]}}, adj});
    if (ni[7]) begin
      dec_idx = '0;
    end else if (ni > $signed({1'b0, iabd_pkg::IDX_MAX})) begin
      dec_idx = iabd_pkg::IDX_MAX;
    end else begin
      dec_idx = ni[6:0];
    end
  end

  always_comb begin
    pred_nxt               = pred_r;
    idx_nxt                = idx_r;
    out_push               = 1'b0;
    out_data.sample        = pred_r;
    out_data.run_end       = cmd_data.run_end;
    out_data.count_reached = cmd_data.count_reached;
    if (fire) begin
      unique case (cmd_data.op)
        iabd_pkg::OP_LOAD_PRED: pred_nxt = $signed(cmd_data.data);
        iabd_pkg::OP_LOAD_IDX:  idx_nxt  = cmd_data.data[6:0];
        iabd_pkg::OP_EMIT:      out_push = 1'b1;
        iabd_pkg::OP_NIB: begin
          pred_nxt        = dec_pred;
          idx_nxt         = dec_idx;
          out_push        = 1'b1;
          out_data.sample = dec_pred;
        end
        default: ;
      endcase
      if (cmd_data.clr) begin
        pred_nxt = '0;
        idx_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pred_r <= '0;
      idx_r  <= '0;
    end else begin
      pred_r <= pred_nxt;
      idx_r  <= idx_nxt;
    end
  end

  // The step index stays within the table.
  assert property (@(posedge clk) disable iff (!rst_n) idx_r <= iabd_pkg::IDX_MAX)
    else $error("step index out of table range");

  // A result is produced only for a command that is taken from the queue.
  assert property (@(posedge clk) disable iff (!rst_n) out_push |-> cmd_pop)
    else $error("result pushed without a command transfer");

  // A clear command leaves predictor and index at zero.
  assert property (@(posedge clk) disable iff (!rst_n)
      (fire && cmd_data.clr) |=> (pred_r == '0 && idx_r == '0))
    else $error("decoder state not cleared");

endmodule

/* design/ima_adpcm_block_decoder_unit.sv */
// ----------------------------------------------------------------------------
// IMA ADPCM block decoder
// Mono 4-bit IMA ADPCM to 16-bit PCM, one stream byte per input transfer.
// ----------------------------------------------------------------------------
// Input channel: drive in_data_byte/in_last_byte with push; a transfer
// happens when push is high and full is low. Result channel: while
// empty is low the oldest sample is on out_sample, out_run_end and
// out_count_reached; pop takes it. Configuration: cfg_wr_en writes
// cfg_data into register cfg_index (0 block_align, 1 sample_count); the
// user writes it only while the decoder is idle; the block does not enforce it.
// The front end classifies each byte (header or data) and queues up to two
// commands; the back end runs one command per cycle while the command queue
// is not empty and the result queue is not full, through the step table and
// predictor clamp. A data byte with two samples keeps full high until its
// second command is queued; a header byte does not. A sample's command is
// queued and its result is queued again before it reaches the result ports.
// Reset clears the stream state and sets block_align to 256 and
// sample_count to 4. When the receiver stops popping, the result queue and
// command queue fill and full rises; nothing is dropped.
// ----------------------------------------------------------------------------
module ima_adpcm_block_decoder_unit #(
  parameter int MAX_BLOCK_ALIGN = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         in_data_byte,
  input  logic               in_last_byte,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] out_sample,
  output logic               out_run_end,
  output logic               out_count_reached
);

  localparam int CMD_W  = $bits(iabd_pkg::cmd_t);
  localparam int SAMP_W = $bits(iabd_pkg::samp_t);

  logic            cmd_push, cmd_full, cmd_empty, cmd_pop;
  iabd_pkg::cmd_t  cmd_wdata, cmd_rdata;
  logic            res_push, res_full;
  iabd_pkg::samp_t res_wdata, res_rdata;

  iabd_front #(
    .MAX_BLOCK_ALIGN(MAX_BLOCK_ALIGN)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_push      (push),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .in_full      (full),
    .cmd_push     (cmd_push),
    .cmd_data     (cmd_wdata),
    .cmd_full     (cmd_full)
  );

  iabd_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(iabd_pkg::CMDQ_DEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_wdata),
    .pop   (cmd_pop),
    .rdata (cmd_rdata),
    .full  (cmd_full),
    .empty (cmd_empty)
  );

  iabd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_data  (cmd_rdata),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .out_push  (res_push),
    .out_data  (res_wdata),
    .out_full  (res_full)
  );

  iabd_fifo #(
    .WIDTH(SAMP_W),
    .DEPTH(iabd_pkg::OUTQ_DEPTH)
  ) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_wdata),
    .pop   (pop),
    .rdata (res_rdata),
    .full  (res_full),
    .empty (empty)
  );

  assign out_sample        = res_rdata.sample;
  assign out_run_end       = res_rdata.run_end;
  assign out_count_reached = res_rdata.count_reached;

endmodule
